>>> src/bssw_pkg.sv
package bssw_pkg;

    localparam int MAX_STAMPS         = 32;
    localparam int AIRBRUSH_PERIOD_MS = 50;
    localparam int MS_PER_S           = 1000;
    localparam int MS_ROUND           = MS_PER_S / 2;
    localparam int CNT_W              = $clog2(MAX_STAMPS + 1);

    localparam int SQRT_STEPS = 25;
    localparam int DIV_STEPS  = 17;
    localparam int IT_W       = $clog2(SQRT_STEPS);

    localparam logic [2:0] REG_SPACING  = 3'd0;
    localparam logic [2:0] REG_WORLD_X  = 3'd1;
    localparam logic [2:0] REG_WORLD_Y  = 3'd2;
    localparam logic [2:0] REG_STRENGTH = 3'd3;
    localparam logic [2:0] REG_AIRBRUSH = 3'd4;

    localparam logic OP_BEGIN   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        KIND_PRESS,
        KIND_SPACED,
        KIND_AIR
    } stamp_kind_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_BEGIN,
        DP_MUL_DX,
        DP_MUL_DY,
        DP_SQ_DX,
        DP_SQ_DY,
        DP_SQ_SP,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_DIV_U_INIT,
        DP_DIV_V_INIT,
        DP_DIV_AIR_INIT,
        DP_DIV_STEP,
        DP_SET_U,
        DP_SPACED,
        DP_AIR_AMT,
        DP_AIR_ADD,
        DP_AIR_STAMP,
        DP_FLUSH
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BEGIN,
        S_MUL_DX,
        S_MUL_DY,
        S_SQ_DX,
        S_SQ_DY,
        S_SQ_SP,
        S_CHECK,
        S_SQRT_INIT,
        S_SQRT,
        S_DIVU_INIT,
        S_DIVU,
        S_SET_U,
        S_DIVV_INIT,
        S_DIVV,
        S_SPACED,
        S_AIR_INIT,
        S_AIR_DIV,
        S_AIR_AMT,
        S_AIR_ADD,
        S_AIR_LOOP,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic push_ok;
        logic pend_valid;
        logic walk_go;
        logic air_go;
        logic air_en;
    } dp_status_t;

endpackage

>>> src/bssw_ctrl.sv
module bssw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 in_op,
    output logic                 s_tready,
    input  bssw_pkg::dp_status_t status,
    output bssw_pkg::dp_op_t     cmd
);

    bssw_pkg::state_t                state_reg, state_next;
    logic [bssw_pkg::IT_W-1:0]       it_reg, it_next;
    logic [bssw_pkg::CNT_W-1:0]      cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bssw_pkg::S_IDLE;
            it_reg    <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            it_reg    <= it_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        it_next    = it_reg;
        cnt_next   = cnt_reg;
        cmd        = bssw_pkg::DP_NOP;
        s_tready   = 1'b0;
        unique case (state_reg)
            bssw_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd      = bssw_pkg::DP_LOAD;
                    cnt_next = '0;
                    state_next = (in_op == bssw_pkg::OP_BEGIN) ? bssw_pkg::S_BEGIN
                                                               : bssw_pkg::S_MUL_DX;
                end
            end
            bssw_pkg::S_BEGIN: begin
                cmd        = bssw_pkg::DP_BEGIN;
                state_next = bssw_pkg::S_FLUSH;
            end
            bssw_pkg::S_MUL_DX: begin
                cmd        = bssw_pkg::DP_MUL_DX;
                state_next = bssw_pkg::S_MUL_DY;
            end
            bssw_pkg::S_MUL_DY: begin
                cmd        = bssw_pkg::DP_MUL_DY;
                state_next = bssw_pkg::S_SQ_DX;
            end
            bssw_pkg::S_SQ_DX: begin
                cmd        = bssw_pkg::DP_SQ_DX;
                state_next = bssw_pkg::S_SQ_DY;
            end
            bssw_pkg::S_SQ_DY: begin
                cmd        = bssw_pkg::DP_SQ_DY;
                state_next = bssw_pkg::S_SQ_SP;
            end
            bssw_pkg::S_SQ_SP: begin
                cmd        = bssw_pkg::DP_SQ_SP;
                state_next = bssw_pkg::S_CHECK;
            end
            bssw_pkg::S_CHECK: begin
                if (cnt_reg == bssw_pkg::CNT_W'(bssw_pkg::MAX_STAMPS) || !status.walk_go) begin
                    state_next = status.air_en ? bssw_pkg::S_AIR_INIT : bssw_pkg::S_FLUSH;
                end else begin
                    state_next = bssw_pkg::S_SQRT_INIT;
                end
            end
            bssw_pkg::S_SQRT_INIT: begin
                cmd        = bssw_pkg::DP_SQRT_INIT;
                it_next    = bssw_pkg::IT_W'(bssw_pkg::SQRT_STEPS - 1);
                state_next = bssw_pkg::S_SQRT;
            end
            bssw_pkg::S_SQRT: begin
                cmd     = bssw_pkg::DP_SQRT_STEP;
                it_next = it_reg - 1'b1;
                if (it_reg == '0) state_next = bssw_pkg::S_DIVU_INIT;
            end
            bssw_pkg::S_DIVU_INIT: begin
                cmd        = bssw_pkg::DP_DIV_U_INIT;
                it_next    = bssw_pkg::IT_W'(bssw_pkg::DIV_STEPS - 1);
                state_next = bssw_pkg::S_DIVU;
            end
            bssw_pkg::S_DIVU: begin
                cmd     = bssw_pkg::DP_DIV_STEP;
                it_next = it_reg - 1'b1;
                if (it_reg == '0) state_next = bssw_pkg::S_SET_U;
            end
            bssw_pkg::S_SET_U: begin
                cmd        = bssw_pkg::DP_SET_U;
                state_next = bssw_pkg::S_DIVV_INIT;
            end
            bssw_pkg::S_DIVV_INIT: begin
                cmd        = bssw_pkg::DP_DIV_V_INIT;
                it_next    = bssw_pkg::IT_W'(bssw_pkg::DIV_STEPS - 1);
                state_next = bssw_pkg::S_DIVV;
            end
            bssw_pkg::S_DIVV: begin
                cmd     = bssw_pkg::DP_DIV_STEP;
                it_next = it_reg - 1'b1;
                if (it_reg == '0) state_next = bssw_pkg::S_SPACED;
            end
            bssw_pkg::S_SPACED: begin
                if (!status.pend_valid || status.push_ok) begin
                    cmd        = bssw_pkg::DP_SPACED;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = bssw_pkg::S_MUL_DX;
                end
            end
            bssw_pkg::S_AIR_INIT: begin
                cmd        = bssw_pkg::DP_DIV_AIR_INIT;
                it_next    = bssw_pkg::IT_W'(bssw_pkg::DIV_STEPS - 1);
                state_next = bssw_pkg::S_AIR_DIV;
            end
            bssw_pkg::S_AIR_DIV: begin
                cmd     = bssw_pkg::DP_DIV_STEP;
                it_next = it_reg - 1'b1;
                if (it_reg == '0) state_next = bssw_pkg::S_AIR_AMT;
            end
            bssw_pkg::S_AIR_AMT: begin
                cmd        = bssw_pkg::DP_AIR_AMT;
                state_next = bssw_pkg::S_AIR_ADD;
            end
            bssw_pkg::S_AIR_ADD: begin
                cmd        = bssw_pkg::DP_AIR_ADD;
                cnt_next   = '0;
                state_next = bssw_pkg::S_AIR_LOOP;
            end
            bssw_pkg::S_AIR_LOOP: begin
                if (cnt_reg == bssw_pkg::CNT_W'(bssw_pkg::MAX_STAMPS) || !status.air_go) begin
                    state_next = bssw_pkg::S_FLUSH;
                end else if (!status.pend_valid || status.push_ok) begin
                    cmd      = bssw_pkg::DP_AIR_STAMP;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            bssw_pkg::S_FLUSH: begin
                if (!status.pend_valid) begin
                    state_next = bssw_pkg::S_IDLE;
                end else if (status.push_ok) begin
                    cmd        = bssw_pkg::DP_FLUSH;
                    state_next = bssw_pkg::S_IDLE;
                end
            end
            default: state_next = bssw_pkg::S_IDLE;
        endcase
    end

endmodule

>>> src/bssw_dp.sv
module bssw_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bssw_pkg::dp_op_t     cmd,
    input  logic [47:0]          s_tdata,
    input  logic [23:0]          stamp_spacing,
    input  logic [23:0]          world_size_x,
    input  logic [23:0]          world_size_y,
    input  logic [15:0]          strength,
    input  logic                 airbrush_on,
    output bssw_pkg::dp_status_t status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // stamp_u, stamp_v, stamp_amount
    output logic [1:0]           m_tuser,   // stamp_kind
    output logic                 m_tlast
);

    logic [15:0] tu_reg, tv_reg, dms_reg;
    logic [15:0] anchor_u_reg, anchor_v_reg, clock_reg;
    logic [23:0] dx_reg, dy_reg;
    logic [48:0] d2_reg;
    logic [47:0] t2_reg, sp2_reg;
    logic [49:0] sq_x_reg;
    logic [26:0] sq_rem_reg;
    logic [24:0] root_reg;
    logic [25:0] div_rem_reg;
    logic [16:0] div_sh_reg, div_q_reg;
    logic [24:0] div_den_reg;
    logic [15:0] step_u_reg, amt_reg;
    logic [15:0] pend_u_reg, pend_v_reg, pend_amt_reg;
    bssw_pkg::stamp_kind_t pend_kind_reg, out_kind_reg;
    logic        pend_valid_reg, m_valid_reg;
    logic [15:0] out_u_reg, out_v_reg, out_amt_reg;
    logic        out_last_reg;

    logic [23:0] sp, mul_a, mul_b;
    logic [47:0] prod;
    logic [15:0] mu, mv, sv, new_u, new_v;
    logic [40:0] num_add, div_num;
    logic [28:0] rem_sh, trial;
    logic        sq_ge, div_ge, push_ok, push, push_last;
    logic [25:0] div_t;
    logic [16:0] clk_sum;

    assign sp = (stamp_spacing == '0) ? 24'd1 : stamp_spacing;
    assign mu = (tu_reg >= anchor_u_reg) ? tu_reg - anchor_u_reg : anchor_u_reg - tu_reg;
    assign mv = (tv_reg >= anchor_v_reg) ? tv_reg - anchor_v_reg : anchor_v_reg - tv_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd)
            bssw_pkg::DP_MUL_DX:       begin mul_a = {8'd0, mu}; mul_b = world_size_x; end
            bssw_pkg::DP_MUL_DY:       begin mul_a = {8'd0, mv}; mul_b = world_size_y; end
            bssw_pkg::DP_SQ_DX:        begin mul_a = dx_reg;     mul_b = dx_reg;       end
            bssw_pkg::DP_SQ_DY:        begin mul_a = dy_reg;     mul_b = dy_reg;       end
            bssw_pkg::DP_SQ_SP:        begin mul_a = sp;         mul_b = sp;           end
            bssw_pkg::DP_DIV_U_INIT:   begin mul_a = {8'd0, mu}; mul_b = sp;           end
            bssw_pkg::DP_DIV_V_INIT:   begin mul_a = {8'd0, mv}; mul_b = sp;           end
            bssw_pkg::DP_DIV_AIR_INIT: begin
                mul_a = {8'd0, strength};
                mul_b = 24'(bssw_pkg::AIRBRUSH_PERIOD_MS);
            end
            default: ;
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign num_add = (cmd == bssw_pkg::DP_DIV_AIR_INIT) ? 41'(bssw_pkg::MS_ROUND)
                                                        : {17'd0, root_reg[24:1]};
    assign div_num = prod[40:0] + num_add;

    assign rem_sh = {sq_rem_reg, sq_x_reg[49:48]};
    assign trial  = {2'd0, root_reg, 2'b01};
    assign sq_ge  = rem_sh >= trial;

    assign div_t  = {div_rem_reg[24:0], div_sh_reg[16]};
    assign div_ge = div_t >= {1'b0, div_den_reg};

    assign sv    = (div_q_reg > {1'b0, mv}) ? mv : div_q_reg[15:0];
    assign new_u = (tu_reg >= anchor_u_reg) ? anchor_u_reg + step_u_reg
                                            : anchor_u_reg - step_u_reg;
    assign new_v = (tv_reg >= anchor_v_reg) ? anchor_v_reg + sv : anchor_v_reg - sv;

    assign clk_sum = {1'b0, clock_reg} + {1'b0, dms_reg};

    assign push_ok   = !m_valid_reg || m_tready;
    assign push_last = (cmd == bssw_pkg::DP_FLUSH);
    assign push      = push_last || (pend_valid_reg && (cmd == bssw_pkg::DP_SPACED ||
                                                        cmd == bssw_pkg::DP_AIR_STAMP));

    always_ff @(posedge aclk) begin
        unique case (cmd)
            bssw_pkg::DP_LOAD: begin
                tu_reg  <= s_tdata[15:0];
                tv_reg  <= s_tdata[31:16];
                dms_reg <= s_tdata[47:32];
            end
            bssw_pkg::DP_MUL_DX: dx_reg  <= prod[39:16];
            bssw_pkg::DP_MUL_DY: dy_reg  <= prod[39:16];
            bssw_pkg::DP_SQ_DX:  d2_reg  <= {1'b0, prod};
            bssw_pkg::DP_SQ_DY:  t2_reg  <= prod;
            bssw_pkg::DP_SQ_SP: begin
                sp2_reg <= prod;
                d2_reg  <= d2_reg + {1'b0, t2_reg};
            end
            bssw_pkg::DP_SQRT_INIT: begin
                sq_x_reg   <= {1'b0, d2_reg};
                sq_rem_reg <= '0;
                root_reg   <= '0;
            end
            bssw_pkg::DP_SQRT_STEP: begin
                sq_x_reg   <= {sq_x_reg[47:0], 2'b00};
                sq_rem_reg <= sq_ge ? 27'(rem_sh - trial) : 27'(rem_sh);
                root_reg   <= {root_reg[23:0], sq_ge};
            end
            bssw_pkg::DP_DIV_U_INIT, bssw_pkg::DP_DIV_V_INIT: begin
                div_rem_reg <= {2'd0, div_num[40:17]};
                div_sh_reg  <= div_num[16:0];
                div_q_reg   <= '0;
                div_den_reg <= root_reg;
            end
            bssw_pkg::DP_DIV_AIR_INIT: begin
                div_rem_reg <= {2'd0, div_num[40:17]};
                div_sh_reg  <= div_num[16:0];
                div_q_reg   <= '0;
                div_den_reg <= 25'(bssw_pkg::MS_PER_S);
            end
            bssw_pkg::DP_DIV_STEP: begin
                div_rem_reg <= div_ge ? div_t - {1'b0, div_den_reg} : div_t;
                div_sh_reg  <= {div_sh_reg[15:0], 1'b0};
                div_q_reg   <= {div_q_reg[15:0], div_ge};
            end
            bssw_pkg::DP_SET_U: step_u_reg <= (div_q_reg > {1'b0, mu}) ? mu : div_q_reg[15:0];
            bssw_pkg::DP_AIR_AMT: amt_reg <= div_q_reg[16] ? 16'hFFFF : div_q_reg[15:0];
            default: ;
        endcase

        if (cmd == bssw_pkg::DP_BEGIN) begin
            pend_u_reg    <= tu_reg;
            pend_v_reg    <= tv_reg;
            pend_amt_reg  <= strength;
            pend_kind_reg <= bssw_pkg::KIND_PRESS;
        end else if (cmd == bssw_pkg::DP_SPACED) begin
            pend_u_reg    <= new_u;
            pend_v_reg    <= new_v;
            pend_amt_reg  <= strength;
            pend_kind_reg <= bssw_pkg::KIND_SPACED;
        end else if (cmd == bssw_pkg::DP_AIR_STAMP) begin
            pend_u_reg    <= tu_reg;
            pend_v_reg    <= tv_reg;
            pend_amt_reg  <= amt_reg;
            pend_kind_reg <= bssw_pkg::KIND_AIR;
        end

        if (push) begin
            out_u_reg    <= pend_u_reg;
            out_v_reg    <= pend_v_reg;
            out_amt_reg  <= pend_amt_reg;
            out_kind_reg <= pend_kind_reg;
            out_last_reg <= push_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anchor_u_reg   <= '0;
            anchor_v_reg   <= '0;
            clock_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd == bssw_pkg::DP_BEGIN) begin
                anchor_u_reg <= tu_reg;
                anchor_v_reg <= tv_reg;
            end else if (cmd == bssw_pkg::DP_SPACED) begin
                anchor_u_reg <= new_u;
                anchor_v_reg <= new_v;
            end

            if (cmd == bssw_pkg::DP_BEGIN) begin
                clock_reg <= '0;
            end else if (cmd == bssw_pkg::DP_AIR_ADD) begin
                clock_reg <= clk_sum[16] ? 16'hFFFF : clk_sum[15:0];
            end else if (cmd == bssw_pkg::DP_AIR_STAMP) begin
                clock_reg <= clock_reg - 16'(bssw_pkg::AIRBRUSH_PERIOD_MS);
            end

            if (cmd == bssw_pkg::DP_FLUSH) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd == bssw_pkg::DP_BEGIN || cmd == bssw_pkg::DP_SPACED ||
                         cmd == bssw_pkg::DP_AIR_STAMP) begin
                pend_valid_reg <= 1'b1;
            end

            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.push_ok    = push_ok;
    assign status.pend_valid = pend_valid_reg;
    assign status.walk_go    = d2_reg >= {1'b0, sp2_reg};
    assign status.air_go     = clock_reg >= 16'(bssw_pkg::AIRBRUSH_PERIOD_MS);
    assign status.air_en     = airbrush_on;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_amt_reg, out_v_reg, out_u_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!m_valid_reg || m_tready))
        else $error("stamp pushed onto a held beat");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == bssw_pkg::DP_FLUSH) |=> !pend_valid_reg)
        else $error("pending stamp survives flush");

    a_air_period: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == bssw_pkg::DP_AIR_STAMP) |-> (clock_reg >= 16'(bssw_pkg::AIRBRUSH_PERIOD_MS)))
        else $error("airbrush stamp without a full period");

endmodule

>>> src/brush_stamp_spacing_walker_unit.sv
// Brush stamp spacing walker.
// Input beats (s_*): tuser = opcode (0 begin, 1 advance); tdata = target_u,
// target_v, delta_ms from bit 0 up. Output beats (m_*): one per stamp; tdata =
// stamp_u, stamp_v, stamp_amount; tuser = stamp_kind; tlast marks the final
// stamp of an input item. An advance item may give no beat at all.
// Configuration over APB at byte addresses 0x0..0x10 (spacing, world x,
// world y, strength, airbrush enable); write only while the block is idle.
// One item is taken at a time. A begin item makes its press stamp pending in
// the begin state and sends it from the flush state once the output has room.
// Each spaced stamp takes the walk test, the 25-step square root and two
// 17-step divisions on the shared divider. With airbrush on, amount division
// and clock update lead, then each airbrush stamp one cycle unless stalled.
// Each stamp is held one step behind so that its tlast is known; a stalled
// receiver holds the output register and the walk waits for it.
// Reset (synchronous, aresetn low) clears the anchor, airbrush clock and
// registers to their defaults and drops any beat in flight.
module brush_stamp_spacing_walker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // target_u, target_v, delta_ms
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // stamp_u, stamp_v, stamp_amount
    output logic [1:0]  m_tuser,   // stamp_kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [23:0] spacing_reg, world_x_reg, world_y_reg;
    logic [15:0] strength_reg;
    logic        airbrush_reg;
    logic        wr_en;

    bssw_pkg::dp_status_t status;
    bssw_pkg::dp_op_t     cmd;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg  <= 24'd256;
            world_x_reg  <= 24'd65536;
            world_y_reg  <= 24'd65536;
            strength_reg <= 16'hFFFF;
            airbrush_reg <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                bssw_pkg::REG_SPACING:  spacing_reg  <= pwdata[23:0];
                bssw_pkg::REG_WORLD_X:  world_x_reg  <= pwdata[23:0];
                bssw_pkg::REG_WORLD_Y:  world_y_reg  <= pwdata[23:0];
                bssw_pkg::REG_STRENGTH: strength_reg <= pwdata[15:0];
                bssw_pkg::REG_AIRBRUSH: airbrush_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            bssw_pkg::REG_SPACING:  prdata = {8'd0, spacing_reg};
            bssw_pkg::REG_WORLD_X:  prdata = {8'd0, world_x_reg};
            bssw_pkg::REG_WORLD_Y:  prdata = {8'd0, world_y_reg};
            bssw_pkg::REG_STRENGTH: prdata = {16'd0, strength_reg};
            bssw_pkg::REG_AIRBRUSH: prdata = {31'd0, airbrush_reg};
            default:                prdata = '0;
        endcase
    end

    bssw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_op    (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bssw_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_tdata       (s_tdata),
        .stamp_spacing (spacing_reg),
        .world_size_x  (world_x_reg),
        .world_size_y  (world_y_reg),
        .strength      (strength_reg),
        .airbrush_on   (airbrush_reg),
        .status        (status),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

endmodule

>>> sim/tb_brush_stamp_spacing_walker_unit.sv
`timescale 1ns / 1ps

module tb_brush_stamp_spacing_walker_unit;

    localparam int  LATENCY_WAIT = 300;
    localparam longint CYCLE_LIMIT = 2_500_000;

    typedef struct {
        logic [15:0] u;
        logic [15:0] v;
        logic [15:0] amount;
        bssw_pkg::stamp_kind_t kind;
        logic        last;
    } stamp_t;

    typedef struct {
        bit          is_reg;
        logic [2:0]  idx;
        logic [31:0] val;
        logic        op;
        logic [15:0] u;
        logic [15:0] v;
        logic [15:0] dms;
        bit          has_exp;
        stamp_t      exp;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // target_u, target_v, delta_ms
    logic        s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // stamp_u, stamp_v, stamp_amount
    logic [1:0]  m_tuser;   // stamp_kind
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    brush_stamp_spacing_walker_unit dut (.*);

    // shadow registers and walker state
    logic [23:0] cfg_spacing;
    logic [23:0] cfg_world_x;
    logic [23:0] cfg_world_y;
    logic [15:0] cfg_strength;
    logic        cfg_air;
    logic [15:0] pos_u;
    logic [15:0] pos_v;
    logic [16:0] air_clock;

    stamp_t      stamp_q[$];
    int          mismatches;
    int          items_sent;
    int          beats_seen;
    int          kind_count[3];
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    longint      cycles;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] walk_coord(logic [15:0] a, logic [15:0] b,
                                               logic [63:0] sp, logic [63:0] root_len);
        logic [63:0] mag;
        logic [63:0] s;
        mag = (b >= a) ? 64'(b - a) : 64'(a - b);
        s = (mag * sp + root_len / 2) / root_len;
        if (s > mag) s = mag;
        return (b >= a) ? 16'(a + s) : 16'(a - s);
    endfunction

    function automatic void push_stamp(logic [15:0] u, logic [15:0] v,
                                       logic [15:0] amt, bssw_pkg::stamp_kind_t k);
        stamp_t s;
        s.u = u; s.v = v; s.amount = amt; s.kind = k; s.last = 1'b0;
        stamp_q.push_back(s);
    endfunction

    function automatic void predict_stamps(logic op, logic [15:0] tu, logic [15:0] tv,
                                           logic [15:0] dms);
        int          n0;
        logic [63:0] sp, mu, mv, dx, dy, d2, root_len;
        logic [31:0] amt;
        n0 = stamp_q.size();
        if (op == bssw_pkg::OP_BEGIN) begin
            air_clock = 0;
            pos_u = tu;
            pos_v = tv;
            push_stamp(tu, tv, cfg_strength, bssw_pkg::KIND_PRESS);
        end else begin
            sp = (cfg_spacing != 0) ? 64'(cfg_spacing) : 64'd1;
            for (int i = 0; i < bssw_pkg::MAX_STAMPS; i++) begin
                mu = (tu >= pos_u) ? 64'(tu - pos_u) : 64'(pos_u - tu);
                mv = (tv >= pos_v) ? 64'(tv - pos_v) : 64'(pos_v - tv);
                dx = (mu * cfg_world_x) >> 16;
                dy = (mv * cfg_world_y) >> 16;
                d2 = dx * dx + dy * dy;
                if (d2 < sp * sp) break;
                root_len = int_sqrt(d2);
                pos_u = walk_coord(pos_u, tu, sp, root_len);
                pos_v = walk_coord(pos_v, tv, sp, root_len);
                push_stamp(pos_u, pos_v, cfg_strength, bssw_pkg::KIND_SPACED);
            end
            if (cfg_air) begin
                amt = (32'(cfg_strength) * bssw_pkg::AIRBRUSH_PERIOD_MS + bssw_pkg::MS_ROUND)
                      / bssw_pkg::MS_PER_S;
                if (amt > 32'hFFFF) amt = 32'hFFFF;
                air_clock = air_clock + dms;
                if (air_clock > 17'hFFFF) air_clock = 17'hFFFF;
                for (int i = 0; i < bssw_pkg::MAX_STAMPS &&
                     air_clock >= bssw_pkg::AIRBRUSH_PERIOD_MS; i++) begin
                    air_clock = air_clock - bssw_pkg::AIRBRUSH_PERIOD_MS;
                    push_stamp(tu, tv, amt[15:0], bssw_pkg::KIND_AIR);
                end
            end
        end
        if (stamp_q.size() > n0) stamp_q[$].last = 1'b1;
    endfunction

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (stamp_q.size() != 0) @(posedge aclk);
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        case (idx)
            bssw_pkg::REG_SPACING:  cfg_spacing  = val[23:0];
            bssw_pkg::REG_WORLD_X:  cfg_world_x  = val[23:0];
            bssw_pkg::REG_WORLD_Y:  cfg_world_y  = val[23:0];
            bssw_pkg::REG_STRENGTH: cfg_strength = val[15:0];
            bssw_pkg::REG_AIRBRUSH: cfg_air      = val[0];
            default: ;
        endcase
    endtask

    task automatic send_item(logic op, logic [15:0] u, logic [15:0] v, logic [15:0] dms);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {dms, v, u};
        do @(posedge aclk); while (!s_tready);
        predict_stamps(op, u, v, dms);
        items_sent++;
    endtask

    function automatic logic [15:0] near(logic [15:0] c, int unsigned span);
        int x;
        x = int'(c) + int'($urandom_range(2 * span)) - int'(span);
        if (x < 0) x = 0;
        if (x > 65535) x = 65535;
        return 16'(x);
    endfunction

    task automatic random_items(int count);
        logic [15:0] tu, tv, dms;
        int unsigned r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 12) begin
                send_item(bssw_pkg::OP_BEGIN, 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (r < 88) begin
                tu  = near(pos_u, 2500);
                tv  = near(pos_v, 2500);
                dms = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(130));
                send_item(bssw_pkg::OP_ADVANCE, tu, tv, dms);
            end else begin
                send_item(1'($urandom_range(1)), 16'($urandom), 16'($urandom),
                          16'($urandom_range(400)));
            end
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        stamp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (m_tuser < 3) kind_count[m_tuser]++;
            if (stamp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat u=%h v=%h amt=%h kind=%0d last=%b",
                             m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser, m_tlast);
            end else begin
                e = stamp_q.pop_front();
                if (m_tdata[15:0] !== e.u || m_tdata[31:16] !== e.v ||
                    m_tdata[47:32] !== e.amount || m_tuser !== e.kind || m_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"beat %0d: exp u=%h v=%h amt=%h kind=%0d last=%b, ",
                                  "got u=%h v=%h amt=%h kind=%0d last=%b"},
                                 beats_seen, e.u, e.v, e.amount, e.kind, e.last,
                                 m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d stamps outstanding", cycles, stamp_q.size());
            $display("** brush_stamp_spacing_walker_unit: FAILED **");
            $finish;
        end
    end

    function automatic row_t blank_row();
        row_t r;
        r.is_reg     = 1'b0;
        r.idx        = '0;
        r.val        = '0;
        r.op         = 1'b0;
        r.u          = '0;
        r.v          = '0;
        r.dms        = '0;
        r.has_exp    = 1'b0;
        r.exp.u      = '0;
        r.exp.v      = '0;
        r.exp.amount = '0;
        r.exp.kind   = bssw_pkg::KIND_PRESS;
        r.exp.last   = 1'b0;
        return r;
    endfunction

    function automatic row_t item_row(logic op, logic [15:0] u, logic [15:0] v, logic [15:0] d);
        row_t r;
        r = blank_row();
        r.op = op; r.u = u; r.v = v; r.dms = d;
        return r;
    endfunction

    function automatic row_t press_row(logic [15:0] u, logic [15:0] v, logic [15:0] amt);
        row_t r;
        r = item_row(bssw_pkg::OP_BEGIN, u, v, 16'd0);
        r.has_exp = 1'b1;
        r.exp = '{u: u, v: v, amount: amt, kind: bssw_pkg::KIND_PRESS, last: 1'b1};
        return r;
    endfunction

    function automatic row_t reg_row(logic [2:0] idx, logic [31:0] val);
        row_t r;
        r = blank_row();
        r.is_reg = 1'b1; r.idx = idx; r.val = val;
        return r;
    endfunction

    initial begin
        row_t   rows[$];
        stamp_t got;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cycles   = 0;
        mismatches = 0; items_sent = 0; beats_seen = 0;
        kind_count = '{0, 0, 0};
        cfg_spacing = 24'd256; cfg_world_x = 24'h10000; cfg_world_y = 24'h10000;
        cfg_strength = 16'hFFFF; cfg_air = 1'b0;
        pos_u = '0; pos_v = '0; air_clock = '0;
        tx_idle_pct = 34; rx_idle_pct = 51;

        rows.push_back(item_row(bssw_pkg::OP_ADVANCE, 16'd1000, 16'd0, 16'd0));
        rows.push_back(press_row(16'd0, 16'd0, 16'hFFFF));
        rows.push_back(press_row(16'hFFFF, 16'hFFFF, 16'hFFFF));
        rows.push_back(item_row(bssw_pkg::OP_ADVANCE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        rows.push_back(item_row(bssw_pkg::OP_ADVANCE, 16'd0, 16'd0, 16'd0));
        rows.push_back(reg_row(bssw_pkg::REG_SPACING, 32'd0));
        rows.push_back(reg_row(bssw_pkg::REG_WORLD_X, 32'd0));
        rows.push_back(item_row(bssw_pkg::OP_ADVANCE, 16'd0, 16'd5, 16'd0));
        rows.push_back(press_row(16'd100, 16'd100, 16'hFFFF));
        rows.push_back(item_row(bssw_pkg::OP_ADVANCE, 16'd300, 16'd100, 16'd0));
        rows.push_back(reg_row(bssw_pkg::REG_WORLD_X, 32'hFFFFFF));
        rows.push_back(reg_row(bssw_pkg::REG_WORLD_Y, 32'hFFFFFF));
        rows.push_back(reg_row(bssw_pkg::REG_SPACING, 32'd1));
        rows.push_back(press_row(16'd0, 16'd0, 16'hFFFF));
        rows.push_back(item_row(bssw_pkg::OP_ADVANCE, 16'd1, 16'd1, 16'd0));   // stalled anchor
        rows.push_back(reg_row(bssw_pkg::REG_STRENGTH, 32'd0));
        rows.push_back(reg_row(bssw_pkg::REG_AIRBRUSH, 32'd1));
        rows.push_back(press_row(16'd42, 16'd42, 16'd0));
        rows.push_back(item_row(bssw_pkg::OP_ADVANCE, 16'd42, 16'd42, 16'hFFFF));
        rows.push_back(item_row(bssw_pkg::OP_ADVANCE, 16'd42, 16'd42, 16'hFFFF)); // saturates
        rows.push_back(reg_row(bssw_pkg::REG_STRENGTH, 32'hFFFF));
        rows.push_back(reg_row(bssw_pkg::REG_SPACING, 32'hFFFFFF));
        rows.push_back(item_row(bssw_pkg::OP_ADVANCE, 16'd7, 16'd9, 16'd49));
        rows.push_back(item_row(bssw_pkg::OP_ADVANCE, 16'd7, 16'd9, 16'd1));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].is_reg) begin
                wait_idle();
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                send_item(rows[i].op, rows[i].u, rows[i].v, rows[i].dms);
                if (rows[i].has_exp) begin
                    got = stamp_q[$];
                    if (got.u !== rows[i].exp.u || got.v !== rows[i].exp.v ||
                        got.amount !== rows[i].exp.amount || got.kind !== rows[i].exp.kind ||
                        got.last !== rows[i].exp.last) begin
                        mismatches++;
                        $display("row %0d: hand expectation differs from prediction", i);
                    end
                end
            end
        end

        for (int p = 0; p < 3; p++) begin
            wait_idle();
            tx_idle_pct = (p == 0) ? 34 : (p == 1) ? 51 : 0;
            rx_idle_pct = (p == 0) ? 51 : (p == 1) ? 34 : 0;
            case (p)
                0: begin
                    write_reg(bssw_pkg::REG_SPACING, 32'd200);
                    write_reg(bssw_pkg::REG_WORLD_X, 32'h10000);
                    write_reg(bssw_pkg::REG_WORLD_Y, 32'h8000);
                    write_reg(bssw_pkg::REG_STRENGTH, $urandom_range(65535));
                    write_reg(bssw_pkg::REG_AIRBRUSH, 32'd1);
                end
                1: begin
                    write_reg(bssw_pkg::REG_SPACING, 32'd4096);
                    write_reg(bssw_pkg::REG_WORLD_X, 32'h40000);
                    write_reg(bssw_pkg::REG_WORLD_Y, 32'h20000);
                    write_reg(bssw_pkg::REG_STRENGTH, 32'hFFFF);
                    write_reg(bssw_pkg::REG_AIRBRUSH, 32'd0);
                end
                default: begin
                    write_reg(bssw_pkg::REG_SPACING, 32'd700);
                    write_reg(bssw_pkg::REG_WORLD_X, 32'h18000);
                    write_reg(bssw_pkg::REG_WORLD_Y, 32'h1);
                    write_reg(bssw_pkg::REG_STRENGTH, 32'd1);
                    write_reg(bssw_pkg::REG_AIRBRUSH, 32'd1);
                end
            endcase
            random_items(60);
        end

        wait_idle();
        $display("%0d items sent, %0d stamps checked (press %0d, spaced %0d, airbrush %0d)",
                 items_sent, beats_seen, kind_count[0], kind_count[1], kind_count[2]);
        $display("%0d mismatches over three handshake pressure phases", mismatches);
        if (mismatches == 0 && stamp_q.size() == 0) begin
            $display("** brush_stamp_spacing_walker_unit: PASSED **");
        end else begin
            $display("** brush_stamp_spacing_walker_unit: FAILED **");
        end
        $finish;
    end

endmodule
